FILE: rtl/nfq_pkg.sv
// Shared types, character codes and word tables for the nonfinite float quoter.
package nfq_pkg;

  // Default depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Number of bytes that may be held while a word is still open.
  localparam int HELD_DEPTH = 3;

  // Character codes that the rewriter cares about.
  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_N      = 8'h6E;
  localparam logic [7:0] CHAR_A      = 8'h61;
  localparam logic [7:0] CHAR_I      = 8'h69;
  localparam logic [7:0] CHAR_F      = 8'h66;

  // Class of one byte, worked out once in the front.
  typedef enum logic [2:0] {
    CLS_OTHER  = 3'd0,
    CLS_QUOTE  = 3'd1,
    CLS_BSLASH = 3'd2,
    CLS_MINUS  = 3'd3,
    CLS_N      = 3'd4,
    CLS_A      = 3'd5,
    CLS_I      = 3'd6,
    CLS_F      = 3'd7
  } chr_class_t;

  // A byte together with its class.
  typedef struct packed {
    logic [7:0] data;
    chr_class_t cls;
  } tok_t;

  // One queued request: the classified byte and the end-of-text mark.
  typedef struct packed {
    tok_t tok;
    logic last;
  } item_t;

  // The bare words, in the order in which they are tried.
  typedef enum logic [1:0] {
    WORD_NEG_NAN = 2'd0,
    WORD_NAN     = 2'd1,
    WORD_NEG_INF = 2'd2,
    WORD_INF     = 2'd3
  } word_t;

  // Length of a word in characters.
  function automatic logic [2:0] word_len(word_t w);
    logic [2:0] len;
    case (w)
      WORD_NEG_NAN: len = 3'd4;
      WORD_NAN:     len = 3'd3;
      WORD_NEG_INF: len = 3'd4;
      WORD_INF:     len = 3'd3;
      default:      len = 3'd3;
    endcase
    return len;
  endfunction

  // Class of character k of a word; positions past the end give CLS_OTHER.
  function automatic chr_class_t word_cls(word_t w, logic [1:0] k);
    chr_class_t c;
    c = CLS_OTHER;
    case (w)
      WORD_NEG_NAN: begin
        case (k)
          2'd0:    c = CLS_MINUS;
          2'd1:    c = CLS_N;
          2'd2:    c = CLS_A;
          default: c = CLS_N;
        endcase
      end
      WORD_NAN: begin
        case (k)
          2'd0:    c = CLS_N;
          2'd1:    c = CLS_A;
          2'd2:    c = CLS_N;
          default: c = CLS_OTHER;
        endcase
      end
      WORD_NEG_INF: begin
        case (k)
          2'd0:    c = CLS_MINUS;
          2'd1:    c = CLS_I;
          2'd2:    c = CLS_N;
          default: c = CLS_F;
        endcase
      end
      WORD_INF: begin
        case (k)
          2'd0:    c = CLS_I;
          2'd1:    c = CLS_N;
          2'd2:    c = CLS_F;
          default: c = CLS_OTHER;
        endcase
      end
      default: c = CLS_OTHER;
    endcase
    return c;
  endfunction

  // Byte value of a character class.
  function automatic logic [7:0] cls_char(chr_class_t c);
    logic [7:0] b;
    case (c)
      CLS_QUOTE:  b = CHAR_QUOTE;
      CLS_BSLASH: b = CHAR_BSLASH;
      CLS_MINUS:  b = CHAR_MINUS;
      CLS_N:      b = CHAR_N;
      CLS_A:      b = CHAR_A;
      CLS_I:      b = CHAR_I;
      CLS_F:      b = CHAR_F;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

  // Byte at a position of the quoted word after its opening quote:
  // the word's characters, then the closing quote.
  function automatic logic [7:0] word_byte(word_t w, logic [2:0] pos);
    logic [7:0] b;
    if (pos < word_len(w)) begin
      b = cls_char(word_cls(w, pos[1:0]));
    end else begin
      b = CHAR_QUOTE;
    end
    return b;
  endfunction

endpackage

FILE: rtl/nfq_front.sv
// Front of the quoter: takes input requests and classifies each byte.
module nfq_front (
  input  logic            byte_valid,
  output logic            byte_ready,
  input  logic [7:0]      in_byte,
  input  logic            text_last,
  output logic            push_valid,
  input  logic            push_ready,
  output nfq_pkg::item_t  push_item
);

  nfq_pkg::chr_class_t cls;

  // Sort the byte into the classes that the back end tests.
  always_comb begin
    case (in_byte)
      nfq_pkg::CHAR_QUOTE:  cls = nfq_pkg::CLS_QUOTE;
      nfq_pkg::CHAR_BSLASH: cls = nfq_pkg::CLS_BSLASH;
      nfq_pkg::CHAR_MINUS:  cls = nfq_pkg::CLS_MINUS;
      nfq_pkg::CHAR_N:      cls = nfq_pkg::CLS_N;
      nfq_pkg::CHAR_A:      cls = nfq_pkg::CLS_A;
      nfq_pkg::CHAR_I:      cls = nfq_pkg::CLS_I;
      nfq_pkg::CHAR_F:      cls = nfq_pkg::CLS_F;
      default:              cls = nfq_pkg::CLS_OTHER;
    endcase
  end

  // A request is taken whenever the queue has room.
  assign push_item.tok.data = in_byte;
  assign push_item.tok.cls  = cls;
  assign push_item.last     = text_last;
  assign push_valid         = byte_valid;
  assign byte_ready         = push_ready;

endmodule

FILE: rtl/nfq_queue.sv
// Short request queue between the front and the back of the quoter.
module nfq_queue #(
  parameter int DEPTH = nfq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  nfq_pkg::item_t  push_item,
  output logic            pop_valid,
  input  logic            pop,
  output nfq_pkg::item_t  pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  nfq_pkg::item_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_en;
  logic             pop_en;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push_en    = push_valid && push_ready;
  assign pop_en     = pop && pop_valid;
  assign pop_item   = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_en) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push_en && !pop_en) begin
        count <= count + CNT_W'(1);
      end else if (pop_en && !push_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/nfq_back.sv
// Back of the quoter: matching engine, replay buffer and result registers.
module nfq_back (
  input  logic            clk,
  input  logic            rst,
  input  nfq_pkg::item_t  q_item,
  input  logic            q_valid,
  output logic            q_pop,
  output logic [7:0]      out_byte,
  output logic            run_end,
  output logic            text_end,
  output logic            result_valid,
  input  logic            result_ready
);

  // Quoting state.
  logic               inside_quotes, inside_quotes_next;
  logic               escape_pending, escape_pending_next;
  nfq_pkg::tok_t      held [nfq_pkg::HELD_DEPTH];
  nfq_pkg::tok_t      held_next [nfq_pkg::HELD_DEPTH];
  logic [1:0]         held_cnt, held_cnt_next;

  // Bytes of a broken prefix waiting to be looked at again.
  nfq_pkg::tok_t      rb [nfq_pkg::HELD_DEPTH];
  nfq_pkg::tok_t      rb_next [nfq_pkg::HELD_DEPTH];
  logic [1:0]         rb_cnt, rb_cnt_next;

  // Sequencer for the rest of a quoted word.
  logic               em_active, em_active_next;
  nfq_pkg::word_t     em_word, em_word_next;
  logic [2:0]         em_pos, em_pos_next;

  logic               cur_last, cur_last_next;

  // Pending byte of the current request, not yet known to be its last.
  logic               p_valid;
  logic [7:0]         p_byte;
  logic               p_final;
  logic               p_text;

  // Step controls.
  logic               o_free;
  logic               adv;
  logic               flush_pend;
  logic               act;
  logic               step_en;
  nfq_pkg::tok_t      step_tok;
  nfq_pkg::tok_t      rest0, rest1;
  logic [1:0]         rest_cnt;
  logic               gen_valid;
  logic [7:0]         gen_byte;
  logic               gen_last;
  logic               gen_done;
  logic               p_out;

  // Match results.
  logic               m_full;
  logic               m_prefix;
  nfq_pkg::word_t     m_word;

  // Compare the held bytes plus the new byte against every word.
  always_comb begin
    nfq_pkg::chr_class_t cand [4];
    logic [2:0]          len;
    logic [2:0]          wl;
    logic                eq;
    m_full   = 1'b0;
    m_prefix = 1'b0;
    m_word   = nfq_pkg::WORD_NEG_NAN;
    len      = {1'b0, held_cnt} + 3'd1;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < {1'b0, held_cnt}) begin
        cand[k] = held[k % nfq_pkg::HELD_DEPTH].cls;
      end else if (3'(k) == {1'b0, held_cnt}) begin
        cand[k] = step_tok.cls;
      end else begin
        cand[k] = nfq_pkg::CLS_OTHER;
      end
    end
    for (int w = 0; w < 4; w++) begin
      wl = nfq_pkg::word_len(nfq_pkg::word_t'(2'(w)));
      eq = (len <= wl);
      for (int k = 0; k < 4; k++) begin
        if (3'(k) < len && cand[k] != nfq_pkg::word_cls(nfq_pkg::word_t'(2'(w)), 2'(k))) begin
          eq = 1'b0;
        end
      end
      if (eq && len == wl && !m_full) begin
        m_full = 1'b1;
        m_word = nfq_pkg::word_t'(2'(w));
      end
      if (eq && len < wl) begin
        m_prefix = 1'b1;
      end
    end
  end

  // One step per unstalled cycle: finish a word, replay, flush or take a request.
  always_comb begin
    logic done;
    inside_quotes_next  = inside_quotes;
    escape_pending_next = escape_pending;
    held_next           = held;
    held_cnt_next       = held_cnt;
    rb_next             = rb;
    rb_cnt_next         = rb_cnt;
    em_active_next      = em_active;
    em_word_next        = em_word;
    em_pos_next         = em_pos;
    cur_last_next       = cur_last;
    gen_valid           = 1'b0;
    gen_byte            = '0;
    gen_last            = cur_last;
    act                 = 1'b0;
    step_en             = 1'b0;
    q_pop               = 1'b0;
    step_tok            = rb[0];
    rest0               = rb[1];
    rest1               = rb[2];
    rest_cnt            = rb_cnt - 2'd1;
    done                = 1'b0;

    o_free     = !result_valid || result_ready;
    adv        = !p_valid || o_free;
    flush_pend = cur_last && (held_cnt != 2'd0);

    // Pick the work for this cycle.
    if (adv) begin
      if (em_active) begin
        act         = 1'b1;
        gen_valid   = 1'b1;
        gen_byte    = nfq_pkg::word_byte(em_word, em_pos);
        em_pos_next = em_pos + 3'd1;
        if (em_pos == nfq_pkg::word_len(em_word)) begin
          em_active_next = 1'b0;
        end
      end else if (rb_cnt != 2'd0) begin
        act     = 1'b1;
        step_en = 1'b1;
      end else if (flush_pend) begin
        act           = 1'b1;
        gen_valid     = 1'b1;
        gen_byte      = held[0].data;
        held_next[0]  = held[1];
        held_next[1]  = held[2];
        held_cnt_next = held_cnt - 2'd1;
      end else if (q_valid) begin
        act           = 1'b1;
        step_en       = 1'b1;
        q_pop         = 1'b1;
        step_tok      = q_item.tok;
        rest_cnt      = 2'd0;
        gen_last      = q_item.last;
        cur_last_next = q_item.last;
      end
    end

    // Examine one byte.
    if (step_en) begin
      rb_next[0]  = rest0;
      rb_next[1]  = rest1;
      rb_cnt_next = rest_cnt;
      if (inside_quotes) begin
        gen_valid = 1'b1;
        gen_byte  = step_tok.data;
        if (escape_pending) begin
          escape_pending_next = 1'b0;
        end else if (step_tok.cls == nfq_pkg::CLS_BSLASH) begin
          escape_pending_next = 1'b1;
        end else if (step_tok.cls == nfq_pkg::CLS_QUOTE) begin
          inside_quotes_next = 1'b0;
        end
      end else if (held_cnt == 2'd0 && step_tok.cls == nfq_pkg::CLS_QUOTE) begin
        gen_valid          = 1'b1;
        gen_byte           = step_tok.data;
        inside_quotes_next = 1'b1;
      end else if (m_full) begin
        gen_valid      = 1'b1;
        gen_byte       = nfq_pkg::CHAR_QUOTE;
        em_active_next = 1'b1;
        em_word_next   = m_word;
        em_pos_next    = 3'd0;
        held_cnt_next  = 2'd0;
      end else if (m_prefix && held_cnt != 2'd3) begin
        held_next[held_cnt] = step_tok;
        held_cnt_next       = held_cnt + 2'd1;
      end else if (held_cnt == 2'd0) begin
        gen_valid = 1'b1;
        gen_byte  = step_tok.data;
      end else begin
        // Broken prefix: give out the first held byte and look at the rest again.
        gen_valid     = 1'b1;
        gen_byte      = held[0].data;
        held_cnt_next = 2'd0;
        case (held_cnt)
          2'd1: begin
            rb_next[0]  = step_tok;
            rb_next[1]  = rest0;
            rb_next[2]  = rest1;
            rb_cnt_next = rest_cnt + 2'd1;
          end
          2'd2: begin
            rb_next[0]  = held[1];
            rb_next[1]  = step_tok;
            rb_next[2]  = rest0;
            rb_cnt_next = rest_cnt + 2'd2;
          end
          default: begin
            rb_next[0]  = held[1];
            rb_next[1]  = held[2];
            rb_next[2]  = step_tok;
            rb_cnt_next = 2'd3;
          end
        endcase
      end
    end

    // The request is finished once nothing of it is left.
    if (act) begin
      done = !em_active_next && (rb_cnt_next == 2'd0)
             && !(gen_last && held_cnt_next != 2'd0);
      if (done && gen_last) begin
        inside_quotes_next  = 1'b0;
        escape_pending_next = 1'b0;
        held_cnt_next       = 2'd0;
      end
    end
    gen_done = act && done;
  end

  // The pending byte moves on once final, on a later byte or at the request end.
  assign p_out = p_valid && o_free && (p_final || gen_valid || gen_done);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_quotes  <= 1'b0;
      escape_pending <= 1'b0;
      held_cnt       <= 2'd0;
      rb_cnt         <= 2'd0;
      em_active      <= 1'b0;
      cur_last       <= 1'b0;
      p_valid        <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      inside_quotes  <= inside_quotes_next;
      escape_pending <= escape_pending_next;
      held_cnt       <= held_cnt_next;
      rb_cnt         <= rb_cnt_next;
      em_active      <= em_active_next;
      cur_last       <= cur_last_next;
      if (gen_valid) begin
        p_valid <= 1'b1;
      end else if (p_out) begin
        p_valid <= 1'b0;
      end
      if (p_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    held    <= held_next;
    rb      <= rb_next;
    em_word <= em_word_next;
    em_pos  <= em_pos_next;
    if (gen_valid) begin
      p_byte  <= gen_byte;
      p_final <= gen_done;
      p_text  <= gen_done && gen_last;
    end
    if (p_out) begin
      out_byte <= p_byte;
      run_end  <= p_final || (gen_done && !gen_valid);
      text_end <= p_final ? p_text : (gen_done && !gen_valid && gen_last);
    end
  end

`ifndef ASSERT_OFF
  a_quote_no_hold: assert property (@(posedge clk) disable iff (rst)
    inside_quotes |-> held_cnt == 2'd0)
    else $error("bytes held inside a string");

  a_escape_in_quote: assert property (@(posedge clk) disable iff (rst)
    escape_pending |-> inside_quotes)
    else $error("escape pending outside a string");

  a_word_no_hold: assert property (@(posedge clk) disable iff (rst)
    em_active |-> held_cnt == 2'd0)
    else $error("bytes held while a word is sent");

  a_open_byte_has_work: assert property (@(posedge clk) disable iff (rst)
    (p_valid && !p_final) |-> (em_active || rb_cnt != 2'd0 || (cur_last && held_cnt != 2'd0)))
    else $error("pending byte not final but its request has no work left");

  a_text_end_run_end: assert property (@(posedge clk) disable iff (rst)
    (result_valid && text_end) |-> run_end)
    else $error("text end without run end");
`endif

endmodule

FILE: rtl/nonfinite_float_quoter.sv
// Top level of the nonfinite float quoter: front, request queue and back.
// Throughput: one request per cycle while each gives at most one result byte and
// the result port is not held back. The result port carries one byte per cycle
// while result_ready is high, so a quoted word gives five or six result bytes and
// a broken prefix replays its held bytes one per cycle.
// Reset: synchronous, clears the queue, quoting state and result_valid at once.
module nonfinite_float_quoter #(
  parameter int QUEUE_DEPTH = nfq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] in_byte,
  input  logic       text_last,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [7:0] out_byte,
  output logic       run_end,
  output logic       text_end
);

  nfq_pkg::item_t push_item;
  logic           push_valid;
  logic           push_ready;
  nfq_pkg::item_t q_item;
  logic           q_valid;
  logic           q_pop;

  // Classify incoming requests.
  nfq_front u_front (
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .in_byte    (in_byte),
    .text_last  (text_last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Decouple the front from the back.
  nfq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  // Rewrite the text and drive the results.
  nfq_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_item       (q_item),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .out_byte     (out_byte),
    .run_end      (run_end),
    .text_end     (text_end),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule
